>>> rtl/core/esu_pkg.sv
// Shared operation codes, error codes and queue item type of the stack unit.
package esu_pkg;

    localparam logic [3:0] MODE_PUSH   = 4'd0;
    localparam logic [3:0] MODE_POP    = 4'd1;
    localparam logic [3:0] MODE_DUP    = 4'd2;
    localparam logic [3:0] MODE_SWAP   = 4'd3;
    localparam logic [3:0] MODE_ADD    = 4'd4;
    localparam logic [3:0] MODE_SUB    = 4'd5;
    localparam logic [3:0] MODE_MSTORE = 4'd6;
    localparam logic [3:0] MODE_MLOAD  = 4'd7;
    localparam logic [3:0] MODE_SSTORE = 4'd8;
    localparam logic [3:0] MODE_SLOAD  = 4'd9;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;
    localparam logic [1:0] ERR_INDEX = 2'd3;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_value;
        logic [7:0]         depth_index;
        logic [6:0]         word_address;
        logic               addr_ok;
    } esu_item_t;

endpackage

>>> rtl/core/evm_style_stack_unit.sv
// Path: the input queue register, then the result register, written at once for push, pop,
// stores, dup of the top, swap by zero, errors and add or sub on under two entries; other dup,
// swap, add, sub and loads first pass the registered stack or word memory read in a wait state.
// Throughput: one item per cycle for direct operations while the result register is free or
// taken; memory reads, and pop from two or more entries to refill the top, hold the executor.
// Reset: stack empty; full is high while the word memories clear, one word of each per cycle.
module evm_style_stack_unit
    import esu_pkg::*;
#(
    parameter int STACK_ENTRIES = 128,
    parameter int MEMORY_WORDS  = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         mode,
    input  logic signed [31:0] operand_value,
    input  logic [7:0]         depth_index,
    input  logic [6:0]         word_address,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result_value,
    output logic [1:0]         error_code,
    output logic [7:0]         stack_depth
);

    esu_item_t item;
    logic      item_valid;
    logic      item_ready;
    logic      clearing;

    esu_front #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .operand_value (operand_value),
        .depth_index   (depth_index),
        .word_address  (word_address),
        .clearing      (clearing),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    esu_exec #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .MEMORY_WORDS  (MEMORY_WORDS)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item_valid),
        .in_ready     (item_ready),
        .in_item      (item),
        .clearing     (clearing),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .error_code   (error_code),
        .stack_depth  (stack_depth)
    );

endmodule

>>> rtl/core/esu_front.sv
// Input side: accepts operations, checks word addresses and queues them for execution.
module esu_front
    import esu_pkg::*;
#(
    parameter int MEMORY_WORDS = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         mode,
    input  logic signed [31:0] operand_value,
    input  logic [7:0]         depth_index,
    input  logic [6:0]         word_address,
    input  logic               clearing,
    output logic               item_valid,
    input  logic               item_ready,
    output esu_item_t          item
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    esu_item_t        q_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             in_xfer;
    logic             out_xfer;
    esu_item_t        new_item;

    assign full       = (count_reg == QCW'(QDEPTH)) || clearing;
    assign in_xfer    = push && !full;
    assign item_valid = (count_reg != '0);
    assign out_xfer   = item_valid && item_ready;
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.mode          = mode;
        new_item.operand_value = operand_value;
        new_item.depth_index   = depth_index;
        new_item.word_address  = word_address;
        new_item.addr_ok       = (13'(word_address) < 13'(MEMORY_WORDS));
    end

    always_comb
    begin
        wr_ptr_next = in_xfer  ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next = out_xfer ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer && !out_xfer)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> rtl/core/esu_exec.sv
// Execution side: stack with cached top, word memories, clearing pass and result register.
module esu_exec
    import esu_pkg::*;
#(
    parameter int STACK_ENTRIES = 128,
    parameter int MEMORY_WORDS  = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  esu_item_t          in_item,
    output logic               clearing,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result_value,
    output logic [1:0]         error_code,
    output logic [7:0]         stack_depth
);

    localparam int DW  = $clog2(STACK_ENTRIES + 1);
    localparam int CW  = (DW > 8 ? DW : 8) + 1;
    localparam int SAW = $clog2(STACK_ENTRIES);
    localparam int MAW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [MAW-1:0]     clr_reg;
    logic [MAW-1:0]     clr_next;
    logic [DW-1:0]      depth_reg;
    logic [DW-1:0]      depth_next;
    logic [7:0]         tos_reg;
    logic [7:0]         tos_next;
    esu_item_t          cur_reg;
    esu_item_t          cur_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out_value_reg;
    logic signed [31:0] out_value_next;
    logic [1:0]         out_err_reg;
    logic [1:0]         out_err_next;
    logic [7:0]         out_depth_reg;
    logic [7:0]         out_depth_next;

    logic [7:0]         stack_mem [STACK_ENTRIES];
    logic [7:0]         st_rd_reg;
    logic               st_we;
    logic [SAW-1:0]     st_waddr;
    logic [7:0]         st_wdata;
    logic               st_re;
    logic [SAW-1:0]     st_raddr;

    logic [31:0]        vol_mem [MEMORY_WORDS];
    logic [31:0]        per_mem [MEMORY_WORDS];
    logic [31:0]        vol_rd_reg;
    logic [31:0]        per_rd_reg;
    logic               vol_we;
    logic               per_we;
    logic               vol_re;
    logic               per_re;
    logic [MAW-1:0]     mem_waddr;
    logic [31:0]        mem_wdata;
    logic [MAW-1:0]     mem_raddr;

    logic               out_can;
    logic [3:0]         mode_sel;
    logic [7:0]         n_sel;
    logic [CW-1:0]      d_w;
    logic [CW-1:0]      n_w;
    logic [CW-1:0]      d_m1;
    logic [CW-1:0]      d_m2;
    logic [CW-1:0]      d_mn;
    logic [CW-1:0]      d_m1n;
    logic               at_full;
    logic [7:0]         alu_a;
    logic [7:0]         alu_b;
    logic [7:0]         alu_r;
    logic [31:0]        alu_wide;
    logic [31:0]        tos_wide;

    assign out_can  = !out_valid_reg || pop;
    assign mode_sel = (state_reg == S_WAIT) ? cur_reg.mode : in_item.mode;
    assign n_sel    = (state_reg == S_WAIT) ? cur_reg.depth_index : in_item.depth_index;
    assign d_w      = CW'(depth_reg);
    assign n_w      = CW'(n_sel);
    assign d_m1     = d_w - CW'(1);
    assign d_m2     = d_w - CW'(2);
    assign d_mn     = d_w - n_w;
    assign d_m1n    = d_m1 - n_w;
    assign at_full  = (d_w >= CW'(STACK_ENTRIES));
    assign alu_a    = (depth_reg != '0) ? tos_reg : 8'd0;
    assign alu_b    = (state_reg == S_WAIT) ? st_rd_reg : 8'd0;
    assign alu_r    = (mode_sel == MODE_SUB) ? alu_a - alu_b : alu_a + alu_b;
    assign alu_wide = {{24{alu_r[7]}}, alu_r};
    assign tos_wide = {{24{tos_reg[7]}}, tos_reg};

    assign clearing     = (state_reg == S_CLEAR);
    assign empty        = !out_valid_reg;
    assign result_value = out_value_reg;
    assign error_code   = out_err_reg;
    assign stack_depth  = out_depth_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        depth_next     = depth_reg;
        tos_next       = tos_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !pop;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_depth_next = out_depth_reg;
        st_we          = 1'b0;
        st_waddr       = d_m1[SAW-1:0];
        st_wdata       = tos_reg;
        st_re          = 1'b0;
        st_raddr       = d_m2[SAW-1:0];
        vol_we         = 1'b0;
        per_we         = 1'b0;
        vol_re         = 1'b0;
        per_re         = 1'b0;
        mem_waddr      = MAW'(in_item.word_address);
        mem_wdata      = in_item.operand_value;
        mem_raddr      = MAW'(in_item.word_address);
        in_ready       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                vol_we    = 1'b1;
                per_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + MAW'(1);
                if (clr_reg == MAW'(MEMORY_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = out_can;
                if (in_valid && out_can)
                begin
                    cur_next       = in_item;
                    out_value_next = '0;
                    out_err_next   = ERR_OK;
                    out_depth_next = 8'(depth_reg);
                    out_valid_next = 1'b1;
                    case (in_item.mode)
                        MODE_PUSH:
                        begin
                            if (at_full)
                            begin
                                out_err_next = ERR_FULL;
                            end
                            else
                            begin
                                st_we          = (depth_reg != '0);
                                tos_next       = in_item.operand_value[7:0];
                                depth_next     = depth_reg + DW'(1);
                                out_depth_next = 8'(depth_reg + DW'(1));
                            end
                        end
                        MODE_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                out_err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                out_value_next = tos_wide;
                                depth_next     = depth_reg - DW'(1);
                                out_depth_next = 8'(depth_reg - DW'(1));
                                if (d_w >= CW'(2))
                                begin
                                    st_re      = 1'b1;
                                    state_next = S_WAIT;
                                end
                            end
                        end
                        MODE_DUP:
                        begin
                            if (n_w == '0 || n_w > d_w)
                            begin
                                out_err_next = ERR_INDEX;
                            end
                            else if (at_full)
                            begin
                                out_err_next = ERR_FULL;
                            end
                            else if (n_w == CW'(1))
                            begin
                                st_we          = 1'b1;
                                depth_next     = depth_reg + DW'(1);
                                out_depth_next = 8'(depth_reg + DW'(1));
                            end
                            else
                            begin
                                st_re          = 1'b1;
                                st_raddr       = d_mn[SAW-1:0];
                                out_valid_next = 1'b0;
                                state_next     = S_WAIT;
                            end
                        end
                        MODE_SWAP:
                        begin
                            if (depth_reg == '0 || n_w > d_m1)
                            begin
                                out_err_next = ERR_INDEX;
                            end
                            else if (n_w != '0)
                            begin
                                st_re          = 1'b1;
                                st_raddr       = d_m1n[SAW-1:0];
                                out_valid_next = 1'b0;
                                state_next     = S_WAIT;
                            end
                        end
                        MODE_ADD, MODE_SUB:
                        begin
                            if (d_w >= CW'(2))
                            begin
                                st_re          = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = S_WAIT;
                            end
                            else
                            begin
                                tos_next       = alu_r;
                                depth_next     = DW'(1);
                                out_value_next = alu_wide;
                                out_err_next   = ERR_EMPTY;
                                out_depth_next = 8'd1;
                            end
                        end
                        MODE_MSTORE, MODE_SSTORE:
                        begin
                            if (!in_item.addr_ok)
                            begin
                                out_err_next = ERR_INDEX;
                            end
                            else
                            begin
                                vol_we = (in_item.mode == MODE_MSTORE);
                                per_we = (in_item.mode == MODE_SSTORE);
                            end
                        end
                        MODE_MLOAD, MODE_SLOAD:
                        begin
                            if (!in_item.addr_ok)
                            begin
                                out_err_next = ERR_INDEX;
                            end
                            else
                            begin
                                vol_re         = (in_item.mode == MODE_MLOAD);
                                per_re         = (in_item.mode == MODE_SLOAD);
                                out_valid_next = 1'b0;
                                state_next     = S_WAIT;
                            end
                        end
                        default:
                        begin
                            out_err_next = ERR_OK;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
                if (cur_reg.mode == MODE_POP)
                begin
                    tos_next = st_rd_reg;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_err_next   = ERR_OK;
                    out_depth_next = 8'(depth_reg);
                    case (cur_reg.mode)
                        MODE_DUP:
                        begin
                            st_we          = 1'b1;
                            tos_next       = st_rd_reg;
                            depth_next     = depth_reg + DW'(1);
                            out_depth_next = 8'(depth_reg + DW'(1));
                        end
                        MODE_SWAP:
                        begin
                            st_we    = 1'b1;
                            st_waddr = d_m1n[SAW-1:0];
                            tos_next = st_rd_reg;
                        end
                        MODE_ADD, MODE_SUB:
                        begin
                            tos_next       = alu_r;
                            depth_next     = depth_reg - DW'(1);
                            out_value_next = alu_wide;
                            out_depth_next = 8'(depth_reg - DW'(1));
                        end
                        MODE_MLOAD:
                        begin
                            out_value_next = vol_rd_reg;
                        end
                        MODE_SLOAD:
                        begin
                            out_value_next = per_rd_reg;
                        end
                        default:
                        begin
                            out_value_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg       <= tos_next;
        cur_reg       <= cur_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
        out_depth_reg <= out_depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rd_reg <= stack_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vol_we)
        begin
            vol_mem[mem_waddr] <= mem_wdata;
        end
        if (vol_re)
        begin
            vol_rd_reg <= vol_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            per_mem[mem_waddr] <= mem_wdata;
        end
        if (per_re)
        begin
            per_rd_reg <= per_mem[mem_raddr];
        end
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d_w <= CW'(STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    a_wait_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && cur_reg.mode != MODE_POP) |-> !out_valid_reg)
        else $error("second cycle finds result register occupied");

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!in_ready && !out_valid_reg))
        else $error("item taken during clearing pass");

    a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && in_ready && in_item.mode == MODE_PUSH
            && !at_full) |=> (depth_reg == $past(depth_reg) + DW'(1)))
        else $error("push did not advance depth");
`endif

endmodule

>>> verif/esu_checker.sv
// Checker for the stack unit: predicts each result from accepted items and compares transfers.
`timescale 1ns / 1ps

module esu_checker
    import esu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [3:0]         mode,
    input  logic signed [31:0] operand_value,
    input  logic [7:0]         depth_index,
    input  logic [6:0]         word_address,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] result_value,
    input  logic [1:0]         error_code,
    input  logic [7:0]         stack_depth,
    output int                 fail_count,
    output int                 pending
);

    localparam int STACK_N = 128;
    localparam int WORDS_N = 128;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         err;
        logic [7:0]         depth;
    } outcome_t;

    logic [7:0]  stk_mem [STACK_N];
    int          stk_count;
    logic [31:0] vol_mem [WORDS_N];
    logic [31:0] per_mem [WORDS_N];

    outcome_t predicted_results [$];
    int       mismatch_count = 0;
    int       awaited_count  = 0;

    assign fail_count = mismatch_count;
    assign pending    = awaited_count;

    task automatic apply_operation(
        input logic [3:0]  op_mode,
        input logic [31:0] operand,
        input logic [7:0]  idx,
        input logic [6:0]  addr
    );
        outcome_t   o;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        logic       got_a;
        logic       got_b;
        int         top;
        o.value = '0;
        o.err   = ERR_OK;
        case (op_mode)
            MODE_PUSH:
            begin
                if (stk_count >= STACK_N)
                    o.err = ERR_FULL;
                else
                begin
                    stk_mem[stk_count] = operand[7:0];
                    stk_count++;
                end
            end
            MODE_POP:
            begin
                if (stk_count == 0)
                    o.err = ERR_EMPTY;
                else
                begin
                    stk_count--;
                    a = stk_mem[stk_count];
                    o.value = {{24{a[7]}}, a};
                end
            end
            MODE_DUP:
            begin
                if (idx == 8'd0 || int'(idx) > stk_count)
                    o.err = ERR_INDEX;
                else if (stk_count >= STACK_N)
                    o.err = ERR_FULL;
                else
                begin
                    stk_mem[stk_count] = stk_mem[stk_count - int'(idx)];
                    stk_count++;
                end
            end
            MODE_SWAP:
            begin
                if (stk_count == 0 || int'(idx) > stk_count - 1)
                    o.err = ERR_INDEX;
                else
                begin
                    top = stk_count - 1;
                    a = stk_mem[top];
                    stk_mem[top] = stk_mem[top - int'(idx)];
                    stk_mem[top - int'(idx)] = a;
                end
            end
            MODE_ADD, MODE_SUB:
            begin
                a = '0;
                b = '0;
                got_a = 1'b0;
                got_b = 1'b0;
                if (stk_count > 0)
                begin
                    stk_count--;
                    a = stk_mem[stk_count];
                    got_a = 1'b1;
                end
                if (stk_count > 0)
                begin
                    stk_count--;
                    b = stk_mem[stk_count];
                    got_b = 1'b1;
                end
                r = (op_mode == MODE_ADD) ? a + b : a - b;
                if (!(got_a && got_b))
                    o.err = ERR_EMPTY;
                if (stk_count >= STACK_N)
                    o.err = ERR_FULL;
                else
                begin
                    stk_mem[stk_count] = r;
                    stk_count++;
                    o.value = {{24{r[7]}}, r};
                end
            end
            MODE_MSTORE, MODE_SSTORE:
            begin
                if (int'(addr) >= WORDS_N)
                    o.err = ERR_INDEX;
                else if (op_mode == MODE_MSTORE)
                    vol_mem[addr] = operand;
                else
                    per_mem[addr] = operand;
            end
            MODE_MLOAD, MODE_SLOAD:
            begin
                if (int'(addr) >= WORDS_N)
                    o.err = ERR_INDEX;
                else
                    o.value = (op_mode == MODE_MLOAD) ? vol_mem[addr] : per_mem[addr];
            end
            default:
            begin
            end
        endcase
        o.depth = stk_count[7:0];
        predicted_results.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            stk_count = 0;
            for (int i = 0; i < STACK_N; i++)
                stk_mem[i] = '0;
            for (int i = 0; i < WORDS_N; i++)
            begin
                vol_mem[i] = '0;
                per_mem[i] = '0;
            end
            predicted_results.delete();
            awaited_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result transfer with no prediction pending");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result_value !== want.value)
                    begin
                        $error("result_value mismatch: expected %0d, got %0d",
                               want.value, result_value);
                        mismatch_count++;
                    end
                    if (error_code !== want.err)
                    begin
                        $error("error_code mismatch: expected %0d, got %0d",
                               want.err, error_code);
                        mismatch_count++;
                    end
                    if (stack_depth !== want.depth)
                    begin
                        $error("stack_depth mismatch: expected %0d, got %0d",
                               want.depth, stack_depth);
                        mismatch_count++;
                    end
                end
            end
            if (push && !full)
                apply_operation(mode, operand_value, depth_index, word_address);
            awaited_count = predicted_results.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the stack unit: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import esu_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 600;
    localparam int BLOCK_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT      = 150;

    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIXED  = 2;

    localparam int BIAS_PLAN [10] = '{BIAS_GROW, BIAS_GROW, BIAS_GROW, BIAS_GROW, BIAS_MIXED,
                                      BIAS_SHRINK, BIAS_SHRINK, BIAS_SHRINK, BIAS_SHRINK,
                                      BIAS_MIXED};

    localparam logic [3:0] MODE_ORDER [10] = '{MODE_PUSH, MODE_DUP, MODE_POP, MODE_SWAP,
                                               MODE_ADD, MODE_SUB, MODE_MSTORE, MODE_MLOAD,
                                               MODE_SSTORE, MODE_SLOAD};

    localparam int MODE_LIMITS [3][10] = '{'{60, 75, 78, 82, 85, 87, 91, 94, 97, 99},
                                           '{ 5,  8, 68, 73, 80, 85, 89, 93, 96, 99},
                                           '{25, 35, 55, 65, 73, 80, 85, 90, 94, 98}};

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               push          = 1'b0;
    logic [3:0]         mode          = MODE_PUSH;
    logic signed [31:0] operand_value = '0;
    logic [7:0]         depth_index   = '0;
    logic [6:0]         word_address  = '0;
    logic               pop           = 1'b0;
    logic               full;
    logic               empty;
    logic signed [31:0] result_value;
    logic [1:0]         error_code;
    logic [7:0]         stack_depth;

    int fail_count;
    int pending;
    int burst_left;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    evm_style_stack_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .operand_value (operand_value),
        .depth_index   (depth_index),
        .word_address  (word_address),
        .empty         (empty),
        .pop           (pop),
        .result_value  (result_value),
        .error_code    (error_code),
        .stack_depth   (stack_depth)
    );

    esu_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .operand_value (operand_value),
        .depth_index   (depth_index),
        .word_address  (word_address),
        .empty         (empty),
        .pop           (pop),
        .result_value  (result_value),
        .error_code    (error_code),
        .stack_depth   (stack_depth),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    task automatic send_item(
        input logic [3:0]  m,
        input logic [31:0] operand,
        input logic [7:0]  idx,
        input logic [6:0]  addr
    );
        mode          <= m;
        operand_value <= operand;
        depth_index   <= idx;
        word_address  <= addr;
        push          <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 30);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random_item(input int bias);
        int          roll;
        logic [3:0]  m;
        logic [31:0] operand;
        logic [7:0]  idx;
        logic [6:0]  addr;
        roll = $urandom_range(0, 99);
        m = MODE_SLOAD + 4'($urandom_range(1, 6));
        for (int k = 9; k >= 0; k--)
            if (roll < MODE_LIMITS[bias][k])
                m = MODE_ORDER[k];
        roll = $urandom_range(0, 19);
        if (roll < 2)
            operand = 32'h8000_0000;
        else if (roll < 4)
            operand = 32'h7FFF_FFFF;
        else if (roll == 4)
            operand = '0;
        else if (roll == 5)
            operand = '1;
        else
            operand = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            idx = 8'($urandom_range(0, 4));
        else if (roll < 7)
            idx = 8'($urandom_range(0, 128));
        else
            idx = 8'($urandom_range(100, 128));
        roll = $urandom_range(0, 9);
        if (roll < 5)
            addr = 7'($urandom_range(0, 7));
        else if (roll == 5)
            addr = '1;
        else
            addr = 7'($urandom_range(0, 127));
        send_item(m, operand, idx, addr);
    endtask

    initial
    begin
        burst_left = $urandom_range(1, 30);
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_POP,    32'h1234_5678, 8'd0,   7'd0);
        send_item(MODE_SWAP,   32'h0,         8'd0,   7'd0);
        send_item(MODE_DUP,    32'h0,         8'd1,   7'd0);
        send_item(MODE_MLOAD,  32'h0,         8'd0,   7'd0);
        send_item(MODE_ADD,    32'hFFFF_FFFF, 8'd0,   7'd0);
        send_item(MODE_SUB,    32'h0,         8'd0,   7'd0);
        send_item(MODE_PUSH,   32'h0000_007F, 8'd0,   7'd0);
        send_item(MODE_PUSH,   32'h8000_0080, 8'd0,   7'd0);
        send_item(MODE_PUSH,   32'hFFFF_FFFF, 8'd255, 7'd127);
        send_item(MODE_DUP,    32'h0,         8'd0,   7'd0);
        send_item(MODE_DUP,    32'h0,         8'd4,   7'd0);
        send_item(MODE_DUP,    32'h0,         8'd128, 7'd0);
        send_item(MODE_SWAP,   32'h0,         8'd0,   7'd0);
        send_item(MODE_SWAP,   32'h0,         8'd3,   7'd0);
        send_item(MODE_SWAP,   32'h0,         8'd128, 7'd0);
        send_item(MODE_ADD,    32'h0,         8'd0,   7'd0);
        send_item(MODE_SUB,    32'h0,         8'd0,   7'd0);
        send_item(MODE_POP,    32'h0,         8'd0,   7'd0);
        send_item(MODE_MSTORE, 32'h8000_0000, 8'd0,   7'd0);
        send_item(MODE_MSTORE, 32'h7FFF_FFFF, 8'd0,   7'd127);
        send_item(MODE_MLOAD,  32'h0,         8'd0,   7'd127);
        send_item(MODE_SSTORE, 32'hFFFF_FFFF, 8'd0,   7'd127);
        send_item(MODE_SLOAD,  32'h0,         8'd0,   7'd127);
        send_item(MODE_SLOAD,  32'h0,         8'd0,   7'd5);
        send_item(4'hF,        32'hFFFF_FFFF, 8'd255, 7'd127);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_random_item(BIAS_PLAN[i / BLOCK_ITEMS]);
        end
        push <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20)
            @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int  taken;
        int  phase_left;
        bit  draining;
        bit  held;
        taken      = 0;
        phase_left = 0;
        draining   = 1'b0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                taken++;
            if (!held && taken >= HOLD_AT)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                if (phase_left <= 0)
                begin
                    draining = !draining;
                    if (draining)
                        phase_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 25);
                    else
                        phase_left = $urandom_range(1, 8);
                end
                pop <= draining;
                phase_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
